// ----- rtl/imu_telemetry_frame_builder_core_macros.svh -----
// Assertion macros shared by the frame builder RTL.
`ifndef IMU_TELEMETRY_FRAME_BUILDER_CORE_MACROS_SVH
`define IMU_TELEMETRY_FRAME_BUILDER_CORE_MACROS_SVH

// Overlapping implication checked at every clock edge outside reset.
`define ITFB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define ITFB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/itfb_pkg.sv -----
// Package with the types, constants and helper function of the frame builder.
package itfb_pkg;

    localparam int NUM_CELLS = 31;
    localparam int NUM_VALUES = 9;

    localparam logic [7:0] RAW_PAYLOAD_LEN = 8'd12;
    localparam logic [7:0] ATT_PAYLOAD_LEN = 8'd28;

    localparam logic [7:0] HEADER_RESET = 8'h88;
    localparam logic [7:0] RAW_CODE_RESET = 8'hA1;
    localparam logic [7:0] ATT_CODE_RESET = 8'hAF;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER   = 2'd0,
        CFG_RAW_CODE = 2'd1,
        CFG_ATT_CODE = 2'd2
    } cfg_idx_t;

    typedef logic [NUM_VALUES-1:0][15:0] value_vec_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // Payload byte at the given payload offset, zero in the padding regions.
    function automatic logic [7:0] payload_byte(input logic [4:0] pos, input value_vec_t vals);
        logic [3:0] slot;
        logic [15:0] word;
        logic [4:0] rel;
        slot = 4'd0;
        rel = pos - 5'd18;
        word = 16'h0000;
        if (pos < 5'd12)
        begin
            slot = 4'(pos >> 1);
            word = vals[slot];
        end
        else if (pos >= 5'd18 && pos < 5'd24)
        begin
            slot = 4'd6 + 4'(rel >> 1);
            word = vals[slot];
        end
        return pos[0] ? word[7:0] : word[15:8];
    endfunction

endpackage

// ----- rtl/itfb_if.sv -----
// Handshake interfaces for the report input, the frame output and the register port.
interface itfb_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [15:0] acc_x;
    logic signed [15:0] acc_y;
    logic signed [15:0] acc_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic        [11:0] yaw_angle;

    modport source (output valid, req_type, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
                    roll_angle, pitch_angle, yaw_angle, input ready);
    modport sink (input valid, req_type, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
                  roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface itfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink (input valid, frame_byte, frame_end, output ready);
endinterface

interface itfb_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/itfb_cell.sv -----
// One byte cell of the frame shift chain, loaded in parallel and shifted toward the head.
module itfb_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  itfb_pkg::cell_ctrl_t ctrl,
    input  logic [7:0]          load_byte,
    input  logic                load_occ,
    input  logic [7:0]          next_byte,
    input  logic                next_occ,
    output logic [7:0]          byte_q,
    output logic                occ_q
);
    import itfb_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       occ_reg;
    logic       occ_next;

    always_comb
    begin
        byte_next = byte_reg;
        occ_next = occ_reg;
        if (ctrl.load)
        begin
            byte_next = load_byte;
            occ_next = load_occ;
        end
        else if (ctrl.shift)
        begin
            byte_next = next_byte;
            occ_next = next_occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;
    assign occ_q = occ_reg;
endmodule

// ----- rtl/imu_telemetry_frame_builder_core.sv -----
// Top level of the frame builder: register file, cell chain, checksum and output register.
// The header word passes from the head cell into the output register before it is shown.
// One frame word per cycle while the output is not stalled, as the cell chain shifts toward the output register.
// A raw report is sent as 16 words and an attitude report as 32, each ending in the checksum word;
// no new report is accepted until the checksum word has moved into the output register.
// Reset clears the chain, the pending checksum and the output valid, and loads register defaults.
module imu_telemetry_frame_builder_core (
    input  logic clk,
    input  logic rst_n,
    itfb_cfg_if.sink    cfg,
    itfb_in_if.sink     report,
    itfb_out_if.source  frame
);
    import itfb_pkg::*;
    `include "imu_telemetry_frame_builder_core_macros.svh"

    logic [7:0] header_reg;
    logic [7:0] raw_code_reg;
    logic [7:0] att_code_reg;

    logic       pend_reg;
    logic       pend_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_end_reg;
    logic       out_end_next;

    logic       accept;
    logic       advance;
    logic       shift;
    cell_ctrl_t ctrl;

    value_vec_t vals;
    logic [7:0] len;
    logic [7:0] code;

    logic [7:0] load_byte [NUM_CELLS];
    logic       load_occ  [NUM_CELLS];
    logic [7:0] next_byte [NUM_CELLS];
    logic       next_occ  [NUM_CELLS];
    logic [7:0] byte_q    [NUM_CELLS];
    logic       occ_q     [NUM_CELLS];
    logic [NUM_CELLS-1:0] occ_vec;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            raw_code_reg <= RAW_CODE_RESET;
            att_code_reg <= ATT_CODE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_HEADER:   header_reg <= cfg.data;
                CFG_RAW_CODE: raw_code_reg <= cfg.data;
                CFG_ATT_CODE: att_code_reg <= cfg.data;
                default:      ;
            endcase
        end
    end

    assign report.ready = !occ_q[0] && !pend_reg;
    assign accept = report.valid && report.ready;
    assign advance = !out_valid_reg || frame.ready;
    assign shift = advance && occ_q[0];
    assign ctrl.load = accept;
    assign ctrl.shift = shift;

    assign vals[0] = report.acc_x;
    assign vals[1] = report.acc_y;
    assign vals[2] = report.acc_z;
    assign vals[3] = report.gyro_x;
    assign vals[4] = report.gyro_y;
    assign vals[5] = report.gyro_z;
    assign vals[6] = report.roll_angle;
    assign vals[7] = {report.pitch_angle[14], report.pitch_angle};
    assign vals[8] = {4'h0, report.yaw_angle};

    assign len = report.req_type ? ATT_PAYLOAD_LEN : RAW_PAYLOAD_LEN;
    assign code = report.req_type ? att_code_reg : raw_code_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (i == 0)
                load_byte[i] = header_reg;
            else if (i == 1)
                load_byte[i] = code;
            else if (i == 2)
                load_byte[i] = len;
            else
                load_byte[i] = payload_byte(5'(i - 3), vals);
            load_occ[i] = (8'(i) < (len + 8'd3));
            if (i == NUM_CELLS - 1)
            begin
                next_byte[i] = 8'h00;
                next_occ[i] = 1'b0;
            end
            else
            begin
                next_byte[i] = byte_q[i + 1];
                next_occ[i] = occ_q[i + 1];
            end
            occ_vec[i] = occ_q[i];
        end
    end

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        itfb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .load_byte (load_byte[g]),
            .load_occ  (load_occ[g]),
            .next_byte (next_byte[g]),
            .next_occ  (next_occ[g]),
            .byte_q    (byte_q[g]),
            .occ_q     (occ_q[g])
        );
    end

    always_comb
    begin
        pend_next = pend_reg;
        sum_next = sum_reg;
        out_valid_next = out_valid_reg;
        out_byte_next = out_byte_reg;
        out_end_next = out_end_reg;
        if (accept)
        begin
            pend_next = 1'b1;
            sum_next = 8'h00;
        end
        if (advance)
        begin
            priority if (occ_q[0])
            begin
                out_valid_next = 1'b1;
                out_byte_next = byte_q[0];
                out_end_next = 1'b0;
                sum_next = sum_reg + byte_q[0];
            end
            else if (pend_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next = sum_reg;
                out_end_next = 1'b1;
                pend_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            sum_reg <= 8'h00;
            out_valid_reg <= 1'b0;
            out_end_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            sum_reg <= sum_next;
            out_valid_reg <= out_valid_next;
            out_end_reg <= out_end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    assign frame.valid = out_valid_reg;
    assign frame.frame_byte = out_byte_reg;
    assign frame.frame_end = out_end_reg;

    `ITFB_ASSERT_NXT(a_load_fills_head, accept, occ_q[0] && pend_reg,
        "accepted report did not fill the head cell")
    `ITFB_ASSERT_IMP(a_idle_chain_empty, !pend_reg, occ_vec == '0,
        "cell chain holds words with no checksum pending")
    `ITFB_ASSERT_NXT(a_end_after_drain, advance && !occ_q[0] && pend_reg,
        out_valid_reg && out_end_reg && !pend_reg,
        "checksum word not shown once the chain drained")
    `ITFB_ASSERT_NXT(a_stall_holds, out_valid_reg && !frame.ready,
        out_valid_reg && $stable(out_byte_reg) && $stable(out_end_reg),
        "stalled output word changed")
endmodule
